// ----- src/fdms_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame DFT magnitude spectrum: shared package
// Types and fixed constants used by the cell chain, the bin unit and the top.
// ----------------------------------------------------------------------------
package fdms_pkg;

    // Widths fixed by the sample and result formats.
    localparam int SAMPLE_W = 16;
    localparam int BIN_W    = 7;

    // Value written in place of bin zero.
    localparam logic signed [SAMPLE_W-1:0] BIN0_MARKER = 16'sd32000;

    // Largest magnitude that still fits once negated.
    localparam logic [SAMPLE_W:0] MAG_LIMIT = 17'd32768;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Control broadcast to every cell of the frame chain.
    typedef struct packed {
        logic cap_shift;   // shift a new sample into the capture row
        logic hld_rot;     // rotate the held row by one place
        logic hld_load;    // copy the capture row into the held row
    } cell_ctrl_t;

    // Status from the bin unit to the top-level sequencer.
    typedef struct packed {
        logic rot;         // the unit consumes the head of the held row
        logic done;        // the bin result is valid for this cycle
    } bin_status_t;

endpackage

// ----- src/fdms_cell.sv -----
// ----------------------------------------------------------------------------
// Frame chain cell
// Holds one capture sample and one held sample and passes both to its
// neighbour: the capture row shifts in samples, the held row rotates.
// ----------------------------------------------------------------------------
module fdms_cell
    import fdms_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  sample_t    cap_in,
    input  sample_t    hld_in,
    output sample_t    cap_out,
    output sample_t    hld_out
);

    sample_t cap_reg;
    sample_t hld_reg;

    // Capture row: take the neighbour's sample on each transaction.
    always_ff @(posedge aclk) begin
        if (ctrl.cap_shift) begin
            cap_reg <= cap_in;
        end
    end

    // Held row: a full-frame load has priority over rotation.
    always_ff @(posedge aclk) begin
        if (ctrl.hld_load) begin
            hld_reg <= cap_reg;
        end else if (ctrl.hld_rot) begin
            hld_reg <= hld_in;
        end
    end

    assign cap_out = cap_reg;
    assign hld_out = hld_reg;

endmodule

// ----- src/fdms_twiddle_rom.sv -----
// ----------------------------------------------------------------------------
// Twiddle table
// Constant cosine and negated sine values in signed Q1 format, built at
// elaboration from a fixed-point Taylor series and read combinationally.
// ----------------------------------------------------------------------------
module fdms_twiddle_rom #(
    parameter int FRAME_SIZE   = 128,
    parameter int TWIDDLE_BITS = 16
) (
    input  logic [$clog2(FRAME_SIZE)-1:0]  idx,
    output logic signed [TWIDDLE_BITS-1:0] tw_re,
    output logic signed [TWIDDLE_BITS-1:0] tw_im
);

    localparam longint Q28_ONE     = 64'sd268435456;
    localparam longint Q28_TWO_PI  = 64'sd1686629713;
    localparam longint Q28_PI      = 64'sd843314857;
    localparam longint Q28_HALF_PI = 64'sd421657428;

    // Round a Q4.28 value to the twiddle format, saturating at +1.0.
    function automatic longint to_twiddle(input longint v);
        longint mag;
        longint r;
        longint lim;
        mag = (v < 0) ? -v : v;
        lim = (64'sd1 <<< (TWIDDLE_BITS - 1)) - 1;
        r = (mag + (64'sd1 <<< (28 - TWIDDLE_BITS))) >>> (29 - TWIDDLE_BITS);
        if (r > lim) begin
            r = lim;
        end
        return (v < 0) ? -r : r;
    endfunction

    logic signed [TWIDDLE_BITS-1:0] tab_re [FRAME_SIZE];
    logic signed [TWIDDLE_BITS-1:0] tab_im [FRAME_SIZE];

    // Constant entries, one per twiddle index. The angle is folded into the
    // first quadrant and both series are summed to ten terms.
    for (genvar m = 0; m < FRAME_SIZE; m++) begin : g_entry
        localparam longint A0   = (Q28_TWO_PI * m) / FRAME_SIZE;
        localparam bit     SNEG = (A0 > Q28_PI);
        localparam longint A1   = SNEG ? Q28_TWO_PI - A0 : A0;
        localparam bit     CNEG = (A1 > Q28_HALF_PI);
        localparam longint A2   = CNEG ? Q28_PI - A1 : A1;
        localparam longint A    = (A2 < 0) ? 64'sd0 : A2;
        localparam longint X2   = (A * A) >>> 28;

        localparam longint S1 = ((A * X2) >>> 28) / 6;
        localparam longint S2 = ((S1 * X2) >>> 28) / 20;
        localparam longint S3 = ((S2 * X2) >>> 28) / 42;
        localparam longint S4 = ((S3 * X2) >>> 28) / 72;
        localparam longint S5 = ((S4 * X2) >>> 28) / 110;
        localparam longint S6 = ((S5 * X2) >>> 28) / 156;
        localparam longint S7 = ((S6 * X2) >>> 28) / 210;
        localparam longint S8 = ((S7 * X2) >>> 28) / 272;
        localparam longint S9 = ((S8 * X2) >>> 28) / 342;
        localparam longint SN = A - S1 + S2 - S3 + S4 - S5 + S6 - S7 + S8 - S9;

        localparam longint C1 = ((Q28_ONE * X2) >>> 28) / 2;
        localparam longint C2 = ((C1 * X2) >>> 28) / 12;
        localparam longint C3 = ((C2 * X2) >>> 28) / 30;
        localparam longint C4 = ((C3 * X2) >>> 28) / 56;
        localparam longint C5 = ((C4 * X2) >>> 28) / 90;
        localparam longint C6 = ((C5 * X2) >>> 28) / 132;
        localparam longint C7 = ((C6 * X2) >>> 28) / 182;
        localparam longint C8 = ((C7 * X2) >>> 28) / 240;
        localparam longint C9 = ((C8 * X2) >>> 28) / 306;
        localparam longint CS = Q28_ONE - C1 + C2 - C3 + C4 - C5 + C6 - C7 + C8 - C9;

        assign tab_re[m] = TWIDDLE_BITS'(to_twiddle(CNEG ? -CS : CS));
        assign tab_im[m] = TWIDDLE_BITS'(to_twiddle(SNEG ? SN : -SN));
    end

    assign tw_re = tab_re[idx];
    assign tw_im = tab_im[idx];

endmodule

// ----- src/fdms_bin_unit.sv -----
// ----------------------------------------------------------------------------
// DFT bin unit
// One complex multiply-accumulate per cycle over the rotating held row,
// then magnitude by squaring and a bit-per-cycle integer square root.
// ----------------------------------------------------------------------------
module fdms_bin_unit
    import fdms_pkg::*;
#(
    parameter int FRAME_SIZE   = 128,
    parameter int TWIDDLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [$clog2(FRAME_SIZE)-1:0] k_in,
    input  sample_t                       x_in,
    output bin_status_t                   status,
    output sample_t                       result
);

    localparam int IDX_W  = $clog2(FRAME_SIZE);
    localparam int PROD_W = SAMPLE_W + TWIDDLE_BITS;
    localparam int ACC_W  = PROD_W + IDX_W;
    localparam int SH     = TWIDDLE_BITS - 8;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_ABS   = 3'd3;
    localparam logic [2:0] S_SQ    = 3'd4;
    localparam logic [2:0] S_SUM   = 3'd5;
    localparam logic [2:0] S_ROOT  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [IDX_W-1:0]        k_reg;
    logic [IDX_W-1:0]        n_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W:0]          idx_sum;
    logic                    pvalid_reg;
    logic signed [PROD_W-1:0] prod_re_reg;
    logic signed [PROD_W-1:0] prod_im_reg;
    logic signed [ACC_W-1:0] acc_re_reg;
    logic signed [ACC_W-1:0] acc_im_reg;
    logic signed [TWIDDLE_BITS-1:0] tw_re;
    logic signed [TWIDDLE_BITS-1:0] tw_im;
    logic [ACC_W-1:0]        abs_re;
    logic [ACC_W-1:0]        abs_im;
    logic [63:0]             ar_wide;
    logic [63:0]             ai_wide;
    logic [30:0]             ar_reg;
    logic [30:0]             ai_reg;
    logic                    ovf_reg;
    logic [61:0]             sq_re_reg;
    logic [61:0]             sq_im_reg;
    logic [63:0]             v_reg;
    logic [63:0]             r_reg;
    logic [63:0]             bit_reg;
    logic [63:0]             trial;
    logic [4:0]              step_reg;
    logic [31:0]             q_shift;
    logic [SAMPLE_W:0]       q_sat;

    fdms_twiddle_rom #(
        .FRAME_SIZE   (FRAME_SIZE),
        .TWIDDLE_BITS (TWIDDLE_BITS)
    ) u_rom (
        .idx   (idx_reg),
        .tw_re (tw_re),
        .tw_im (tw_im)
    );

    // Sequencer for one bin.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (start) state_next = S_MAC;
            S_MAC:   if (n_reg == IDX_W'(FRAME_SIZE - 1)) state_next = S_DRAIN;
            S_DRAIN: state_next = S_ABS;
            S_ABS:   state_next = S_SQ;
            S_SQ:    state_next = S_SUM;
            S_SUM:   state_next = S_ROOT;
            S_ROOT:  if (step_reg == 5'd31) state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            pvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pvalid_reg <= (state_reg == S_MAC);
        end
    end

    // Twiddle index steps by k modulo the frame size.
    assign idx_sum = {1'b0, idx_reg} + {1'b0, k_reg};

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && start) begin
            k_reg   <= k_in;
            n_reg   <= '0;
            idx_reg <= '0;
        end else if (state_reg == S_MAC) begin
            n_reg <= n_reg + 1'b1;
            if (idx_sum >= (IDX_W + 1)'(FRAME_SIZE)) begin
                idx_reg <= IDX_W'(idx_sum - (IDX_W + 1)'(FRAME_SIZE));
            end else begin
                idx_reg <= IDX_W'(idx_sum);
            end
        end
    end

    // Product stage, then accumulation in the cycle after.
    always_ff @(posedge aclk) begin
        prod_re_reg <= PROD_W'(x_in) * PROD_W'(tw_re);
        prod_im_reg <= PROD_W'(x_in) * PROD_W'(tw_im);
        if (state_reg == S_IDLE && start) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if (pvalid_reg) begin
            acc_re_reg <= acc_re_reg + ACC_W'(prod_re_reg);
            acc_im_reg <= acc_im_reg + ACC_W'(prod_im_reg);
        end
    end

    // Absolute values with seven fractional bits left.
    assign abs_re  = acc_re_reg[ACC_W-1] ? ACC_W'(-acc_re_reg) : ACC_W'(acc_re_reg);
    assign abs_im  = acc_im_reg[ACC_W-1] ? ACC_W'(-acc_im_reg) : ACC_W'(acc_im_reg);
    assign ar_wide = 64'(abs_re >> SH);
    assign ai_wide = 64'(abs_im >> SH);

    always_ff @(posedge aclk) begin
        if (state_reg == S_ABS) begin
            ar_reg  <= ar_wide[30:0];
            ai_reg  <= ai_wide[30:0];
            ovf_reg <= (|ar_wide[63:31]) || (|ai_wide[63:31]);
        end
        if (state_reg == S_SQ) begin
            sq_re_reg <= ar_reg * ar_reg;
            sq_im_reg <= ai_reg * ai_reg;
        end
    end

    // Integer square root, one result bit per cycle.
    assign trial = r_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == S_SUM) begin
            v_reg    <= 64'(sq_re_reg) + 64'(sq_im_reg);
            r_reg    <= '0;
            bit_reg  <= 64'd1 << 62;
            step_reg <= '0;
        end else if (state_reg == S_ROOT) begin
            step_reg <= step_reg + 1'b1;
            bit_reg  <= bit_reg >> 2;
            if (v_reg >= trial) begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
        end
    end

    // Scale, saturate and negate.
    assign q_shift = 32'(r_reg >> 11);
    assign q_sat   = (ovf_reg || q_shift > 32'(MAG_LIMIT)) ? MAG_LIMIT
                                                          : (SAMPLE_W + 1)'(q_shift);

    assign result      = SAMPLE_W'((SAMPLE_W + 1)'(0) - q_sat);
    assign status.rot  = (state_reg == S_MAC);
    assign status.done = (state_reg == S_DONE);

endmodule

// ----- src/frame_dft_magnitude_spectrum.sv -----
// ----------------------------------------------------------------------------
// Frame DFT magnitude spectrum
// Gathers samples into frames in a chain of cells, transforms the previous
// frame one bin per sample and streams out the stored spectrum.
//
//   Channel | Ports                          | Carries
//   input   | s_valid s_ready s_sample_in    | one audio sample
//   result  | m_valid m_ready m_spectrum_out | one bin value and its index
//           | m_bin_index                    |
//
// Each transaction runs the multiply-accumulate over the whole frame in the
// single multiply-accumulate unit, then drain, absolute, square and sum
// steps, the bit-serial square root, a done step, a bank swap step after the
// last sample of a frame only, a settle step and the idle state that takes the
// next sample. The result of a transaction is ready in the cycle after it is
// accepted. Reset clears the fill position, bank select and valid flags; the
// spectrum reads as zero until the first transform lands. A stalled result
// stops the next input transaction only while the result register is full.
// ----------------------------------------------------------------------------
module frame_dft_magnitude_spectrum
    import fdms_pkg::*;
#(
    parameter int FRAME_SIZE   = 128,
    parameter int TWIDDLE_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  sample_t          s_sample_in,
    output logic             m_valid,
    input  logic             m_ready,
    output sample_t          m_spectrum_out,
    output logic [BIN_W-1:0] m_bin_index
);

    localparam int IDX_W  = $clog2(FRAME_SIZE);
    localparam int ADDR_W = $clog2(2 * FRAME_SIZE);

    localparam logic [1:0] T_IDLE   = 2'd0;
    localparam logic [1:0] T_BUSY   = 2'd1;
    localparam logic [1:0] T_SWAP   = 2'd2;
    localparam logic [1:0] T_SETTLE = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] k_reg;
    logic             rbank_reg;
    logic             held_valid_reg;
    logic             spec_valid_reg;
    logic             m_valid_reg;
    sample_t          m_spectrum_reg;
    logic [BIN_W-1:0] m_bin_reg;
    sample_t          rd_reg;
    logic             accept;
    cell_ctrl_t       ctrl;
    bin_status_t      bin_st;
    sample_t          bin_result;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    sample_t cap_out [FRAME_SIZE];
    sample_t hld_out [FRAME_SIZE];

    sample_t spec_mem [2 * FRAME_SIZE];

    assign s_ready = (state_reg == T_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // Chain control.
    assign ctrl.cap_shift = accept;
    assign ctrl.hld_rot   = bin_st.rot;
    assign ctrl.hld_load  = (state_reg == T_SWAP);

    // Row of frame cells; the held row wraps round from its head.
    for (genvar i = 0; i < FRAME_SIZE; i++) begin : g_cell
        localparam int NXT = (i + 1) % FRAME_SIZE;
        fdms_cell u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .cap_in  ((i == FRAME_SIZE - 1) ? s_sample_in : cap_out[NXT]),
            .hld_in  (hld_out[NXT]),
            .cap_out (cap_out[i]),
            .hld_out (hld_out[i])
        );
    end

    fdms_bin_unit #(
        .FRAME_SIZE   (FRAME_SIZE),
        .TWIDDLE_BITS (TWIDDLE_BITS)
    ) u_bin (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .k_in    (pos_reg),
        .x_in    (hld_out[0]),
        .status  (bin_st),
        .result  (bin_result)
    );

    // Sequencer: one bin per transaction, bank swap at the end of a frame.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE: if (accept) state_next = T_BUSY;
            T_BUSY: begin
                if (bin_st.done) begin
                    state_next = (k_reg == IDX_W'(FRAME_SIZE - 1)) ? T_SWAP : T_SETTLE;
                end
            end
            T_SWAP:   state_next = T_SETTLE;
            T_SETTLE: state_next = T_IDLE;
            default:  state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= T_IDLE;
            pos_reg        <= '0;
            rbank_reg      <= 1'b0;
            held_valid_reg <= 1'b0;
            spec_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                pos_reg <= (pos_reg == IDX_W'(FRAME_SIZE - 1)) ? '0 : pos_reg + 1'b1;
            end
            if (state_reg == T_SWAP) begin
                held_valid_reg <= 1'b1;
                if (held_valid_reg) begin
                    rbank_reg      <= ~rbank_reg;
                    spec_valid_reg <= 1'b1;
                end
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result register and bin number of the running transform.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_spectrum_reg <= spec_valid_reg ? rd_reg : '0;
            m_bin_reg      <= BIN_W'(pos_reg);
            k_reg          <= pos_reg;
        end
    end

    // Spectrum store: two banks, one written by the transform, one read out.
    assign wr_addr = ADDR_W'(k_reg) + (rbank_reg ? ADDR_W'(0) : ADDR_W'(FRAME_SIZE));
    assign rd_addr = ADDR_W'(pos_reg) + (rbank_reg ? ADDR_W'(FRAME_SIZE) : ADDR_W'(0));

    always_ff @(posedge aclk) begin
        if (state_reg == T_BUSY && bin_st.done) begin
            spec_mem[wr_addr] <= (k_reg == '0) ? BIN0_MARKER : bin_result;
        end
        rd_reg <= spec_mem[rd_addr];
    end

    assign m_valid        = m_valid_reg;
    assign m_spectrum_out = m_spectrum_reg;
    assign m_bin_index    = m_bin_reg;

    // An accepted transaction closes the input until its bin is computed.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input open straight after a transaction");

    // The bin unit finishes only while the sequencer waits for it.
    a_done_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        bin_st.done |-> (state_reg == T_BUSY))
        else $error("bin result outside the busy state");

    // Once a spectrum is stored it stays valid until reset.
    a_spec_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        spec_valid_reg |=> spec_valid_reg)
        else $error("spectrum valid flag dropped");

    // Banks only swap once a held frame exists.
    a_swap_needs_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (rbank_reg != $past(rbank_reg)) |-> $past(held_valid_reg))
        else $error("bank swap without a held frame");

endmodule
